FILE: rtl/stf_pkg.sv
package stf_pkg;

  localparam int PIX_W        = 8;
  localparam int SUM_W        = 11;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd768;

  // Job queue between the front and back halves.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  // One line buffer entry: the row above the middle row and the middle row.
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_t;

  // Which of the three possible results a job carries.
  typedef struct packed {
    logic res_a;
    logic res_b;
    logic res_c;
  } res_mask_t;

  typedef struct packed {
    sum_t      sum_a;
    sum_t      sum_b;
    sum_t      sum_c;
    res_mask_t mask;
  } calc_t;

  localparam int CALC_W = $bits(calc_t);

endpackage

FILE: rtl/stf_queue.sv
module stf_queue #(
  parameter int DATA_W = 58
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              full,
  output logic              empty
);

  localparam int CNT_W = stf_pkg::QPTR_W + 1;

  logic [DATA_W-1:0]         slot_r [stf_pkg::QDEPTH];
  logic [stf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [stf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(stf_pkg::QDEPTH));
  assign empty     = (cnt_r == '0);
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/stf_front.sv
module stf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [stf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [stf_pkg::PIX_W-1:0]       in_pixel,
  input  logic                            q_full,
  output logic                            push,
  output stf_pkg::calc_t                  calc,
  output logic [$clog2(MAX_HEIGHT)-1:0]   job_row,
  output logic [$clog2(MAX_WIDTH)-1:0]    job_col
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CXW = (CW + 1 > stf_pkg::WIDTH_CFG_W) ? CW + 1 : stf_pkg::WIDTH_CFG_W;
  localparam int RXW = (RW + 1 > stf_pkg::HEIGHT_CFG_W) ? RW + 1 : stf_pkg::HEIGHT_CFG_W;

  logic [stf_pkg::WIDTH_CFG_W-1:0]  width_r, width_nxt;
  logic [stf_pkg::HEIGHT_CFG_W-1:0] height_r, height_nxt;
  logic [CW-1:0]                    col_r, col_nxt;
  logic [RW-1:0]                    row_r, row_nxt;
  stf_pkg::pix_t                    prev_r, prev2_r, left_mid_r;

  // Line buffer: one write per pixel, two registered reads that prefetch
  // the entries at the next column and the one after it.
  stf_pkg::line_t line_mem [MAX_WIDTH];
  stf_pkg::line_t rd0_r, rd1_r, wr_entry;
  logic [CW-1:0]  addr0, addr1;

  logic accept, end_col, last_row;
  logic c_ge1, c_ge2, r_ge1, r_ge2;
  logic [CXW-1:0] col_p1;
  logic [RXW-1:0] row_p1;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  assign col_p1   = CXW'(col_r) + CXW'(1);
  assign row_p1   = RXW'(row_r) + RXW'(1);
  // A zero size compares as a size of one; sizes beyond the buffer clamp to it.
  assign end_col  = (col_p1 >= CXW'(width_r)) || (col_r == CW'(MAX_WIDTH - 1));
  assign last_row = (row_p1 >= RXW'(height_r)) || (row_r == RW'(MAX_HEIGHT - 1));

  assign c_ge1 = (col_r != '0);
  assign c_ge2 = (col_r != '0) && (col_r != CW'(1));
  assign r_ge1 = (row_r != '0);
  assign r_ge2 = (row_r != '0) && (row_r != RW'(1));

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (stf_pkg::cfg_idx_t'(cfg_index))
        stf_pkg::CFG_IMAGE_WIDTH:  width_nxt  = cfg_wdata[stf_pkg::WIDTH_CFG_W-1:0];
        stf_pkg::CFG_IMAGE_HEIGHT: height_nxt = cfg_wdata[stf_pkg::HEIGHT_CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (end_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  assign addr0 = col_nxt;
  assign addr1 = (col_nxt == CW'(MAX_WIDTH - 1)) ? '0 : col_nxt + 1'b1;

  // The old middle value moves to the upper row as soon as the pixel lands;
  // later reads of the old value come from left_mid_r.
  assign wr_entry = '{upper: rd0_r.middle, middle: in_pixel};

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_r] <= wr_entry;
    end
    rd0_r <= (accept && addr0 == col_r) ? wr_entry : line_mem[addr0];
    rd1_r <= (accept && addr1 == col_r) ? wr_entry : line_mem[addr1];
  end

  always_comb begin
    stf_pkg::sum_t sa, sb, sc;
    sa = (stf_pkg::SUM_W'(rd0_r.middle) << 1) + stf_pkg::SUM_W'(in_pixel);
    if (c_ge1) begin
      sa = sa + stf_pkg::SUM_W'(left_mid_r) + stf_pkg::SUM_W'(prev_r);
    end
    if (!end_col) begin
      sa = sa + stf_pkg::SUM_W'(rd1_r.middle);
    end
    if (r_ge2) begin
      sa = sa + stf_pkg::SUM_W'(rd0_r.upper);
      if (!end_col) begin
        sa = sa + stf_pkg::SUM_W'(rd1_r.upper);
      end
    end

    sb = (stf_pkg::SUM_W'(prev_r) << 1) + stf_pkg::SUM_W'(in_pixel);
    if (c_ge2) begin
      sb = sb + stf_pkg::SUM_W'(prev2_r);
    end
    if (r_ge1) begin
      sb = sb + stf_pkg::SUM_W'(left_mid_r) + stf_pkg::SUM_W'(rd0_r.middle);
    end

    sc = stf_pkg::SUM_W'(in_pixel) << 1;
    if (c_ge1) begin
      sc = sc + stf_pkg::SUM_W'(prev_r);
    end
    if (r_ge1) begin
      sc = sc + stf_pkg::SUM_W'(rd0_r.middle);
    end

    calc.sum_a      = sa;
    calc.sum_b      = sb;
    calc.sum_c      = sc;
    calc.mask.res_a = r_ge1;
    calc.mask.res_b = last_row && c_ge1;
    calc.mask.res_c = last_row && end_col;
  end

  assign push    = accept && (calc.mask.res_a || calc.mask.res_b || calc.mask.res_c);
  assign job_row = row_r;
  assign job_col = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= stf_pkg::WIDTH_RESET;
      height_r <= stf_pkg::HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      prev_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      if (accept) begin
        prev_r <= in_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev2_r    <= prev_r;
      left_mid_r <= rd0_r.middle;
    end
  end

endmodule

FILE: rtl/stf_back.sv
module stf_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [stf_pkg::CALC_W+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)-1:0] q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stf_pkg::SUM_W-1:0]     out_smoothed_eighths,
  output logic [$clog2(MAX_HEIGHT)-1:0] out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
  output logic                          out_frame_last
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int DATA_W = stf_pkg::CALC_W + RW + CW;

  stf_pkg::calc_t     calc;
  logic [RW-1:0]      job_row;
  logic [CW-1:0]      job_col;
  stf_pkg::res_mask_t done_r, done_nxt, pend, pick;
  logic               load, rest;

  logic                      out_valid_r, out_valid_nxt;
  logic [stf_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic [CW-1:0]             col_r, col_nxt;
  logic                      last_r, last_nxt;

  assign calc    = stf_pkg::calc_t'(q_head[DATA_W-1 -: stf_pkg::CALC_W]);
  assign job_row = q_head[RW+CW-1:CW];
  assign job_col = q_head[CW-1:0];

  // The output register takes a new word when it is empty or being drained.
  assign load = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    pend.res_a = calc.mask.res_a && !done_r.res_a;
    pend.res_b = calc.mask.res_b && !done_r.res_b;
    pend.res_c = calc.mask.res_c && !done_r.res_c;
    pick       = '0;
    rest       = 1'b0;
    sum_nxt    = sum_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    last_nxt   = last_r;
    priority if (pend.res_a) begin
      pick.res_a = 1'b1;
      rest       = pend.res_b || pend.res_c;
      sum_nxt    = calc.sum_a;
      row_nxt    = job_row - 1'b1;
      col_nxt    = job_col;
      last_nxt   = 1'b0;
    end else if (pend.res_b) begin
      pick.res_b = 1'b1;
      rest       = pend.res_c;
      sum_nxt    = calc.sum_b;
      row_nxt    = job_row;
      col_nxt    = job_col - 1'b1;
      last_nxt   = 1'b0;
    end else begin
      pick.res_c = 1'b1;
      sum_nxt    = calc.sum_c;
      row_nxt    = job_row;
      col_nxt    = job_col;
      last_nxt   = 1'b1;
    end
  end

  assign q_pop = load && !rest;

  always_comb begin
    done_nxt = done_r;
    if (load) begin
      done_nxt = rest ? (done_r | pick) : '0;
    end
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r  <= sum_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_smoothed_eighths = sum_r;
  assign out_row              = row_r;
  assign out_col              = col_r;
  assign out_frame_last       = last_r;

endmodule

FILE: rtl/smooth_3x3_stencil_filter.sv
// A result enters the job queue on the edge that accepts the pixel completing it
// and then moves to the output register. Throughput: one pixel per cycle while
// the job queue is not full, set by the single-write, dual-read line buffer; in the
// last row a pixel yields up to two results, the frame's last up to three, on one port.
// Reset (rst_n low, synchronous): counters clear, size returns to 1024 x 768, the job
// queue and output register empty; the line buffer is not cleared.
module smooth_3x3_stencil_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [stf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [stf_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [stf_pkg::SUM_W-1:0]      out_smoothed_eighths,
  output logic [$clog2(MAX_HEIGHT)-1:0]  out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]   out_col,
  output logic                           out_frame_last
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int DATA_W = stf_pkg::CALC_W + RW + CW;

  logic              q_full, q_empty, q_push, q_pop;
  stf_pkg::calc_t    calc;
  logic [RW-1:0]     job_row;
  logic [CW-1:0]     job_col;
  logic [DATA_W-1:0] q_wdata, q_head;

  stf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .q_full   (q_full),
    .push     (q_push),
    .calc     (calc),
    .job_row  (job_row),
    .job_col  (job_col)
  );

  assign q_wdata = {calc, job_row, job_col};

  stf_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .head_data(q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  stf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_smoothed_eighths(out_smoothed_eighths),
    .out_row             (out_row),
    .out_col             (out_col),
    .out_frame_last      (out_frame_last)
  );

endmodule
